// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file kped_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define KPED_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising edge, reset included
`define KPED_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/kped_pkg.sv
// Shared types and constants of the key press event detector
package kped_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int HOLD_BITS      = 10;
    localparam int WINDOW_BITS    = 7;
    localparam int COUNT_BITS     = 8;
    localparam int CODE_BITS      = 8;

    localparam logic [HOLD_BITS-1:0]   HOLD_MAX         = 10'd1000;
    localparam logic [HOLD_BITS-1:0]   LONG_PRESS_RESET = 10'd200;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET     = 7'd75;
    localparam logic [CODE_BITS-1:0]   IDLE_RESET       = 8'd255;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IDLE_CODE      = 2'd0,
        REG_LONG_PRESS     = 2'd1,
        REG_REPEAT_WINDOW  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef struct packed {
        logic held;
        logic long_press;
        logic down;
        logic up;
    } kped_flags_t;

endpackage

// File: rtl/core/kped_cfg_regs.sv
// Configuration register file of the key press event detector
module kped_cfg_regs
    import kped_pkg::*;
#(
    parameter int KEY_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic [KEY_BITS-1:0]       idle_code,
    output logic [HOLD_BITS-1:0]      long_press_ticks,
    output logic [WINDOW_BITS-1:0]    repeat_window_ticks
);

    localparam logic [KEY_BITS-1:0] KEY_MASK = KEY_BITS'(255);

    logic [KEY_BITS-1:0]    idle_code_reg;
    logic [HOLD_BITS-1:0]   long_press_reg;
    logic [WINDOW_BITS-1:0] window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_code_reg  <= KEY_BITS'(IDLE_RESET) & KEY_MASK;
            long_press_reg <= LONG_PRESS_RESET;
            window_reg     <= WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IDLE_CODE:
                begin
                    idle_code_reg <= KEY_BITS'(cfg_data[CODE_BITS-1:0]) & KEY_MASK;
                end
                REG_LONG_PRESS:
                begin
                    long_press_reg <= cfg_data[HOLD_BITS-1:0];
                end
                REG_REPEAT_WINDOW:
                begin
                    window_reg <= cfg_data[WINDOW_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign idle_code           = idle_code_reg;
    assign long_press_ticks    = long_press_reg;
    assign repeat_window_ticks = window_reg;

endmodule

// File: rtl/core/kped_update.sv
// Next-state logic for one tick or clear item
module kped_update
    import kped_pkg::*;
#(
    parameter int KEY_BITS = 8
)
(
    input  logic                   action,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [KEY_BITS-1:0]    idle_code,
    input  logic [HOLD_BITS-1:0]   long_press_ticks,
    input  logic [WINDOW_BITS-1:0] repeat_window_ticks,
    input  logic [KEY_BITS-1:0]    last_sample,
    input  logic [KEY_BITS-1:0]    quick_last_key,
    input  logic [KEY_BITS-1:0]    latched_key,
    input  logic [COUNT_BITS-1:0]  repeat_count,
    input  logic [HOLD_BITS-1:0]   hold_ticks,
    input  logic [WINDOW_BITS-1:0] window_left,
    input  kped_flags_t            flags,
    output logic [KEY_BITS-1:0]    last_sample_next,
    output logic [KEY_BITS-1:0]    quick_last_key_next,
    output logic [KEY_BITS-1:0]    latched_key_next,
    output logic [COUNT_BITS-1:0]  repeat_count_next,
    output logic [HOLD_BITS-1:0]   hold_ticks_next,
    output logic [WINDOW_BITS-1:0] window_left_next,
    output kped_flags_t            flags_next
);

    logic [HOLD_BITS-1:0]   hold_inc;
    logic [WINDOW_BITS-1:0] window_mid;
    logic [COUNT_BITS-1:0]  count_mid;
    logic [KEY_BITS-1:0]    quick_mid;

    always_comb
    begin
        last_sample_next    = last_sample;
        quick_last_key_next = quick_last_key;
        latched_key_next    = latched_key;
        repeat_count_next   = repeat_count;
        hold_ticks_next     = hold_ticks;
        window_left_next    = window_left;
        flags_next          = flags;
        hold_inc            = (hold_ticks < HOLD_MAX) ? hold_ticks + 1'b1 : hold_ticks;
        window_mid          = window_left;
        count_mid           = repeat_count;
        quick_mid           = quick_last_key;

        if (action_t'(action) == ACT_CLEAR)
        begin
            flags_next = '0;
        end
        else
        begin
            if (key != idle_code)
            begin
                if (key == last_sample)
                begin
                    flags_next.held = 1'b1;
                    hold_ticks_next = hold_inc;
                    if (hold_inc == long_press_ticks)
                    begin
                        flags_next.long_press = 1'b1;
                    end
                end
                else
                begin
                    count_mid        = (key == quick_last_key) ? repeat_count + 1'b1
                                                               : COUNT_BITS'(1);
                    window_mid       = repeat_window_ticks;
                    last_sample_next = key;
                    latched_key_next = key;
                    quick_mid        = key;
                    flags_next.down  = 1'b1;
                    hold_ticks_next  = '0;
                end
            end
            else
            begin
                flags_next.held = 1'b0;
                if (last_sample != key)
                begin
                    last_sample_next = key;
                    if (hold_ticks < long_press_ticks)
                    begin
                        flags_next.up = 1'b1;
                    end
                end
                hold_ticks_next = '0;
            end

            // count down the repeat window
            if (window_mid != '0)
            begin
                window_left_next    = window_mid - 1'b1;
                repeat_count_next   = count_mid;
                quick_last_key_next = (window_mid == WINDOW_BITS'(1)) ? idle_code : quick_mid;
            end
            else
            begin
                window_left_next    = window_mid;
                repeat_count_next   = '0;
                quick_last_key_next = quick_mid;
            end
        end
    end

endmodule

// File: rtl/core/key_press_event_detector_top.sv
// Path: each accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while out_ready is high; the result register frees as it is taken.
// Each item reads the state left by the previous one through one level of compare/count logic.
// Reset: flags, counters, keys and pipeline valids clear; configuration returns to defaults.
// Configuration writes are taken in every cycle.
module key_press_event_detector_top
    import kped_pkg::*;
#(
    parameter int KEY_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic [KEY_BITS-1:0]       key_sample,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      key_held,
    output logic                      long_press,
    output logic                      down_event,
    output logic                      up_event,
    output logic [KEY_BITS-1:0]       reported_key,
    output logic [COUNT_BITS-1:0]     quick_count,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [KEY_BITS-1:0] KEY_MASK = KEY_BITS'(255);

    logic [KEY_BITS-1:0]    idle_code;
    logic [HOLD_BITS-1:0]   long_press_ticks;
    logic [WINDOW_BITS-1:0] repeat_window_ticks;

    logic                s1_valid_reg;
    logic                s1_action_reg;
    logic [KEY_BITS-1:0] s1_key_reg;
    logic                s1_advance;

    logic [KEY_BITS-1:0]    last_sample_reg,    last_sample_next;
    logic [KEY_BITS-1:0]    quick_last_key_reg, quick_last_key_next;
    logic [KEY_BITS-1:0]    latched_key_reg,    latched_key_next;
    logic [COUNT_BITS-1:0]  repeat_count_reg,   repeat_count_next;
    logic [HOLD_BITS-1:0]   hold_ticks_reg,     hold_ticks_next;
    logic [WINDOW_BITS-1:0] window_left_reg,    window_left_next;
    kped_flags_t            flags_reg,          flags_next;

    logic out_valid_reg;

    kped_cfg_regs #(
        .KEY_BITS(KEY_BITS)
    ) u_cfg (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .idle_code           (idle_code),
        .long_press_ticks    (long_press_ticks),
        .repeat_window_ticks (repeat_window_ticks)
    );

    kped_update #(
        .KEY_BITS(KEY_BITS)
    ) u_update (
        .action              (s1_action_reg),
        .key                 (s1_key_reg),
        .idle_code           (idle_code),
        .long_press_ticks    (long_press_ticks),
        .repeat_window_ticks (repeat_window_ticks),
        .last_sample         (last_sample_reg),
        .quick_last_key      (quick_last_key_reg),
        .latched_key         (latched_key_reg),
        .repeat_count        (repeat_count_reg),
        .hold_ticks          (hold_ticks_reg),
        .window_left         (window_left_reg),
        .flags               (flags_reg),
        .last_sample_next    (last_sample_next),
        .quick_last_key_next (quick_last_key_next),
        .latched_key_next    (latched_key_next),
        .repeat_count_next   (repeat_count_next),
        .hold_ticks_next     (hold_ticks_next),
        .window_left_next    (window_left_next),
        .flags_next          (flags_next)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign cfg_ready  = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_key_reg    <= key_sample & KEY_MASK;
        end
    end

    // detector state, advanced as each item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg    <= '0;
            quick_last_key_reg <= '0;
            latched_key_reg    <= '0;
            repeat_count_reg   <= '0;
            hold_ticks_reg     <= '0;
            window_left_reg    <= '0;
            flags_reg          <= '0;
        end
        else if (s1_advance)
        begin
            last_sample_reg    <= last_sample_next;
            quick_last_key_reg <= quick_last_key_next;
            latched_key_reg    <= latched_key_next;
            repeat_count_reg   <= repeat_count_next;
            hold_ticks_reg     <= hold_ticks_next;
            window_left_reg    <= window_left_next;
            flags_reg          <= flags_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_held     = flags_reg.held;
    assign long_press   = flags_reg.long_press;
    assign down_event   = flags_reg.down;
    assign up_event     = flags_reg.up;
    assign reported_key = latched_key_reg;
    assign quick_count  = repeat_count_reg;

endmodule

// File: rtl/core/kped_checker.sv
// Port-level checker for the key press event detector, with its bind
`include "assert_macros.svh"

module kped_checker
    import kped_pkg::*;
#(
    parameter int KEY_BITS = 8
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      key_held,
    input logic                      long_press,
    input logic                      down_event,
    input logic                      up_event,
    input logic [KEY_BITS-1:0]       reported_key,
    input logic [COUNT_BITS-1:0]     quick_count
);

    `KPED_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(reported_key) && $stable(quick_count), "result item changed while stalled")
    `KPED_ASSERT(a_flags_hold, clk, rst_n, out_valid && !out_ready |=> $stable(key_held) && $stable(long_press) && $stable(down_event) && $stable(up_event), "result flags changed while stalled")
    `KPED_ASSERT(a_ready_flow, clk, rst_n, out_ready |-> in_ready, "input stalled while output side is ready")
    `KPED_ASSERT(a_empty_ready, clk, rst_n, !out_valid |-> in_ready, "input stalled with no result pending")

endmodule

bind key_press_event_detector_top kped_checker #(.KEY_BITS(KEY_BITS)) u_kped_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the key press event detector top level
`timescale 1ns / 1ps

module testbench;
    import kped_pkg::*;

    localparam int                      CLK_HALF   = 6;
    localparam int                      STALL_MAX  = 1000;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        kped_flags_t            flags;
        logic [CODE_BITS-1:0]   key;
        logic [COUNT_BITS-1:0]  count;
    } key_report_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      action;
    logic [CODE_BITS-1:0]      key_sample;
    logic                      out_valid;
    logic                      out_ready;
    logic                      key_held;
    logic                      long_press;
    logic                      down_event;
    logic                      up_event;
    logic [CODE_BITS-1:0]      reported_key;
    logic [COUNT_BITS-1:0]     quick_count;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // detector state as it should be after each accepted item
    logic [CODE_BITS-1:0]   idle_cfg;
    logic [HOLD_BITS-1:0]   long_cfg;
    logic [WINDOW_BITS-1:0] window_cfg;
    logic [CODE_BITS-1:0]   prev_key;
    logic [CODE_BITS-1:0]   repeat_key;
    logic [CODE_BITS-1:0]   shown_key;
    logic [COUNT_BITS-1:0]  repeat_cnt;
    logic [HOLD_BITS-1:0]   hold_cnt;
    logic [WINDOW_BITS-1:0] window_cnt;
    kped_flags_t            flags;

    key_report_t pending_reports[$];
    int          sent_items;
    int          result_count = 0;
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          item_gaps;
    bit          ready_stalls;

    key_press_event_detector_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .key_sample   (key_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_held     (key_held),
        .long_press   (long_press),
        .down_event   (down_event),
        .up_event     (up_event),
        .reported_key (reported_key),
        .quick_count  (quick_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic reset_detector_model();
        idle_cfg   = IDLE_RESET;
        long_cfg   = LONG_PRESS_RESET;
        window_cfg = WINDOW_RESET;
        prev_key   = '0;
        repeat_key = '0;
        shown_key  = '0;
        repeat_cnt = '0;
        hold_cnt   = '0;
        window_cnt = '0;
        flags      = '0;
    endtask

    function key_report_t advance_detector(action_t act, logic [CODE_BITS-1:0] key);
        key_report_t rep;
        if (act == ACT_CLEAR)
        begin
            flags = '0;
        end
        else
        begin
            if (key != idle_cfg)
            begin
                if (key == prev_key)
                begin
                    flags.held = 1'b1;
                    if (hold_cnt < HOLD_MAX)
                        hold_cnt = hold_cnt + 1'b1;
                    if (hold_cnt == long_cfg)
                        flags.long_press = 1'b1;
                end
                else
                begin
                    repeat_cnt = (key == repeat_key) ? repeat_cnt + 1'b1 : 8'd1;
                    window_cnt = window_cfg;
                    prev_key   = key;
                    shown_key  = key;
                    repeat_key = key;
                    flags.down = 1'b1;
                    hold_cnt   = '0;
                end
            end
            else
            begin
                flags.held = 1'b0;
                if (prev_key != key)
                begin
                    prev_key = key;
                    if (hold_cnt < long_cfg)
                        flags.up = 1'b1;
                end
                hold_cnt = '0;
            end
            if (window_cnt != 0)
            begin
                window_cnt = window_cnt - 1'b1;
                if (window_cnt == 0)
                    repeat_key = idle_cfg;
            end
            else
            begin
                repeat_cnt = '0;
            end
        end
        rep.flags = flags;
        rep.key   = shown_key;
        rep.count = repeat_cnt;
        return rep;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      result_count, name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        key_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_count));
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("key_held", key_held, want.flags.held);
                check_field("long_press", long_press, want.flags.long_press);
                check_field("down_event", down_event, want.flags.down);
                check_field("up_event", up_event, want.flags.up);
                check_field("reported_key", reported_key, want.key);
                check_field("quick_count", quick_count, want.count);
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_MAX)
            begin
                $display("** key_press_event_detector_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (ready_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(action_t act, logic [CODE_BITS-1:0] key);
        if (item_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        key_sample <= key;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_reports.push_back(advance_detector(act, key));
        sent_items++;
    endtask

    task automatic tick(logic [CODE_BITS-1:0] key);
        send_item(ACT_TICK, key);
    endtask

    task automatic clear_flags();
        send_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IDLE_CODE:     idle_cfg   = data[CODE_BITS-1:0];
            REG_LONG_PRESS:    long_cfg   = data[HOLD_BITS-1:0];
            REG_REPEAT_WINDOW: window_cfg = data[WINDOW_BITS-1:0];
            default:           ;
        endcase
    endtask

    // press, hold and release cycles on a few keys, with clears and stray codes mixed in
    task automatic run_sessions(int n);
        logic [CODE_BITS-1:0] pool[3];
        logic [CODE_BITS-1:0] key;
        int start;
        int hold_len;
        int r;
        start = sent_items;
        foreach (pool[i])
            pool[i] = 8'($urandom_range(0, 255));
        while (sent_items - start < n)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                clear_flags();
            end
            else if (r == 1)
            begin
                tick(8'($urandom_range(0, 255)));
            end
            else
            begin
                key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : pool[$urandom_range(0, 2)];
                if (key == idle_cfg)
                    key = key ^ 8'h01;
                hold_len = $urandom_range(0, (long_cfg <= 30) ? long_cfg + 2 : 12);
                repeat (hold_len + 1) tick(key);
                repeat ($urandom_range(0, 5)) tick(idle_cfg);
            end
        end
    endtask

    task automatic test_basic_presses();
        tick(8'd0);
        tick(8'd0);
        tick(8'd0);
        tick(8'd255);
        tick(8'd0);
        tick(8'd255);
        tick(8'd0);
        clear_flags();
        tick(8'd255);
        tick(8'd0);
        tick(8'd170);
        tick(8'd85);
        tick(8'd85);
        clear_flags();
        tick(8'd255);
        tick(8'd1);
        tick(8'd254);
        tick(8'd128);
        tick(8'd127);
        clear_flags();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_IDLE_CODE, 16'd0);
        write_reg(REG_LONG_PRESS, 16'd1);
        write_reg(REG_REPEAT_WINDOW, 16'd1);
        tick(8'd0);
        tick(8'd255);
        tick(8'd255);
        tick(8'd0);
        tick(8'd255);
        tick(8'd0);
        clear_flags();
        write_reg(REG_LONG_PRESS, 16'd0);
        write_reg(REG_REPEAT_WINDOW, 16'd0);
        tick(8'd7);
        tick(8'd7);
        tick(8'd0);
        tick(8'd7);
        clear_flags();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_LONG_PRESS, 16'd1023);
        write_reg(REG_REPEAT_WINDOW, 16'd127);
        write_reg(REG_IDLE_CODE, 16'd128);
        tick(8'd128);
        tick(8'd127);
        tick(8'd128);
        tick(8'd127);
        tick(8'd127);
        tick(8'd128);
    endtask

    task automatic test_long_hold();
        write_reg(REG_IDLE_CODE, 16'd255);
        write_reg(REG_LONG_PRESS, 16'd40);
        clear_flags();
        repeat (45) tick(8'h42);
        tick(8'd255);
        clear_flags();
        write_reg(REG_LONG_PRESS, 16'd50);
        repeat (30) tick(8'hBD);
        tick(8'd255);
    endtask

    task automatic test_random_sessions();
        int r;
        item_gaps    = 1'b1;
        ready_stalls = 1'b1;
        for (int phase = 0; phase < 5; phase++)
        begin
            r = $urandom_range(0, 2);
            write_reg(REG_IDLE_CODE, {8'($urandom_range(0, 255)),
                      (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255))});
            r = $urandom_range(0, 9);
            write_reg(REG_LONG_PRESS, {6'($urandom_range(0, 63)),
                      (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : (r == 2) ? 10'd999
                               : 10'($urandom_range(1, 24))});
            r = $urandom_range(0, 5);
            write_reg(REG_REPEAT_WINDOW, {9'($urandom_range(0, 511)),
                      (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(1, 20))});
            if (phase == 2)
                write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
            run_sessions(75);
        end
    endtask

    task automatic test_steady_flow();
        item_gaps    = 1'b0;
        ready_stalls = 1'b0;
        write_reg(REG_IDLE_CODE, 16'd0);
        write_reg(REG_LONG_PRESS, 16'd6);
        write_reg(REG_REPEAT_WINDOW, 16'd9);
        run_sessions(60);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_TICK;
        key_sample   <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_IDLE_CODE;
        cfg_data     <= '0;
        sent_items   = 0;
        item_gaps    = 1'b1;
        ready_stalls = 1'b1;
        reset_detector_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_presses();
        test_register_extremes();
        test_long_hold();
        test_random_sessions();
        test_steady_flow();

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("** key_press_event_detector_top: PASSED **");
        else
            $display("** key_press_event_detector_top: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/kped_pkg.sv
rtl/core/kped_cfg_regs.sv
rtl/core/kped_update.sv
rtl/core/key_press_event_detector_top.sv
rtl/core/kped_checker.sv
tb/testbench.sv
